// ===== design/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared constants, codes and types for the first-fit range allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

   localparam int FREE_ENTRIES = 16;
   localparam int USED_ENTRIES = 16;
   localparam int ADDR_BITS    = 48;
   localparam int GRAN_BITS    = 31;
   localparam int MAX_ENTRIES  = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
   localparam int IDX_W        = $clog2(MAX_ENTRIES);
   localparam int CNT_W        = IDX_W + 1;
   localparam int DIV_CNT_W    = $clog2(ADDR_BITS + 1);

   // request codes
   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_INIT  = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_NOFIT    = 3'd2;
   localparam logic [2:0] ST_NOTALLOC = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   // register indexes
   localparam logic CSR_POOL_SIZE    = 1'b0;
   localparam logic CSR_GRANULE_SIZE = 1'b1;

   typedef struct packed {
      logic [ADDR_BITS-1:0] start;
      logic [ADDR_BITS-1:0] length;
   } range_type;

   // one update of a range table per cycle
   typedef struct packed {
      logic             wr_en;
      logic             ins_en;
      logic [IDX_W-1:0] wr_idx;
      range_type        wr_data;
      logic             drop_en;
      logic [IDX_W-1:0] drop_idx;
   } table_op_type;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_ROUND  = 9'b000000010,
      S_ASCAN  = 9'b000000100,
      S_ACOMMIT= 9'b000001000,
      S_USCAN  = 9'b000010000,
      S_FSCAN  = 9'b000100000,
      S_FDECIDE= 9'b001000000,
      S_FMERGE = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

// ===== design/ffra_rem_unit.sv =====
// ----------------------------------------------------------------------------
// ffra_rem_unit
// Bit-serial restoring divider that returns the remainder of size / granule,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_rem_unit
   import ffra_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [ADDR_BITS-1:0] dividend,
   input  wire logic [GRAN_BITS-1:0] divisor,
   output logic                      done,
   output logic [GRAN_BITS-1:0]      remainder
);

   logic [ADDR_BITS-1:0] shift_ff, shift_in;
   logic [GRAN_BITS-1:0] rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [GRAN_BITS:0]   trial;

   // shift one dividend bit into the partial remainder, subtract if it fits
   always_comb begin
      trial    = {rem_ff, shift_ff[ADDR_BITS-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = DIV_CNT_W'(ADDR_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[ADDR_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = GRAN_BITS'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[GRAN_BITS-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== design/first_fit_range_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_range_allocator_unit
// First-fit range allocator with a sorted free-range table, an allocated
// table and coalescing on free.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_type, req_request_size,
//          |           |                      |   req_free_offset
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_status, rsp_alloc_offset,
//          |           |                      |   rsp_granted_size
//  csr     | in        | csr_we               | csr_index, csr_wdata
//
// Allocate: load and run the remainder unit, scan the free entries in order,
// commit on a hit while the allocated table has room, then load the response.
// Free: scan the allocated entries, then the free entries, decide, merge when
// extending the previous range, then load the response. Init and unknown codes
// go straight to loading the response.
// The block waits in the done state while an earlier response is held, then
// returns to the idle state, the only state in which a new transaction is taken.
// Synchronous reset empties both tables by clearing their counts.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_range_allocator_unit
   import ffra_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_type,
   input  wire logic [ADDR_BITS-1:0] req_request_size,
   input  wire logic [ADDR_BITS-1:0] req_free_offset,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [2:0]                rsp_status,
   output logic [ADDR_BITS-1:0]      rsp_alloc_offset,
   output logic [ADDR_BITS-1:0]      rsp_granted_size,
   input  wire logic                 csr_we,
   input  wire logic                 csr_index,
   input  wire logic [ADDR_BITS-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [ADDR_BITS-1:0] pool_ff;
   logic [GRAN_BITS-1:0] gran_ff;

   range_type free_tbl_ff [FREE_ENTRIES];
   range_type used_tbl_ff [USED_ENTRIES];
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0] used_cnt_ff, used_cnt_in;

   logic [1:0]           type_ff;
   logic [ADDR_BITS-1:0] size_ff, off_ff;
   logic [ADDR_BITS-1:0] rnd_ff, rnd_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     jdx_ff, jdx_in;
   range_type            cur_ff, cur_in;
   logic [2:0]           st_ff, st_in;
   logic [ADDR_BITS-1:0] aoff_ff, aoff_in;
   logic [ADDR_BITS-1:0] gsz_ff, gsz_in;

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic [ADDR_BITS-1:0] rsp_off_ff, rsp_gsz_ff;

   table_op_type free_op, used_op;

   logic                 req_fire;
   logic                 div_done;
   logic [GRAN_BITS-1:0] div_rem;
   logic [GRAN_BITS-1:0] gran_eff;
   logic [ADDR_BITS:0]   round_sum;
   logic [CNT_W-1:0]     idx_next;
   range_type            free_rd, free_rd_next, used_rd;
   logic                 ins_mode;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign gran_eff  = (gran_ff == '0) ? GRAN_BITS'(1) : gran_ff;
   assign idx_next  = idx_ff + 1'b1;

   // read ports addressed by the scan index; the free table also reads the next entry
   assign free_rd      = free_tbl_ff[idx_ff[IDX_W-1:0]];
   assign free_rd_next = free_tbl_ff[idx_next[IDX_W-1:0]];
   assign used_rd      = used_tbl_ff[idx_ff[IDX_W-1:0]];

   // round up: add granule minus remainder, carry out means overflow
   assign round_sum = {1'b0, size_ff} +
                      ((div_rem == '0) ? '0 :
                       (ADDR_BITS+1)'(gran_eff - div_rem));

   ffra_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire && (req_type == REQ_ALLOC)),
      .dividend  (req_request_size),
      .divisor   (gran_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      rnd_in      = rnd_ff;
      idx_in      = idx_ff;
      jdx_in      = jdx_ff;
      cur_in      = cur_ff;
      st_in       = st_ff;
      aoff_in     = aoff_ff;
      gsz_in      = gsz_ff;
      free_cnt_in = free_cnt_ff;
      used_cnt_in = used_cnt_ff;
      free_op     = '0;
      used_op     = '0;
      ins_mode    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               st_in   = ST_OK;
               aoff_in = '0;
               gsz_in  = '0;
               idx_in  = '0;
               unique case (req_type)
                  REQ_ALLOC: state_in = S_ROUND;
                  REQ_FREE:  state_in = S_USCAN;
                  REQ_INIT: begin
                     free_op.wr_en   = 1'b1;
                     free_op.wr_idx  = '0;
                     free_op.wr_data = '{start: '0, length: pool_ff};
                     free_cnt_in     = CNT_W'(1);
                     used_cnt_in     = '0;
                     state_in        = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_ROUND: begin
            if (div_done) begin
               rnd_in  = round_sum[ADDR_BITS] ? '1 : round_sum[ADDR_BITS-1:0];
               gsz_in  = round_sum[ADDR_BITS] ? '1 : round_sum[ADDR_BITS-1:0];
               if (free_cnt_ff == '0) begin
                  st_in    = ST_EMPTY;
                  state_in = S_DONE;
               end else if (round_sum[ADDR_BITS]) begin
                  st_in    = ST_NOFIT;
                  state_in = S_DONE;
               end else begin
                  state_in = S_ASCAN;
               end
            end
         end
         S_ASCAN: begin
            if (idx_ff == free_cnt_ff) begin
               st_in    = ST_NOFIT;
               state_in = S_DONE;
            end else if (free_rd.length >= rnd_ff) begin
               cur_in = free_rd;
               if (used_cnt_ff >= CNT_W'(USED_ENTRIES)) begin
                  st_in    = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  state_in = S_ACOMMIT;
               end
            end else begin
               idx_in = idx_next;
            end
         end
         S_ACOMMIT: begin
            // trim the hit range or drop it on an exact fit, record the pair
            if (cur_ff.length == rnd_ff) begin
               free_op.drop_en  = 1'b1;
               free_op.drop_idx = idx_ff[IDX_W-1:0];
               free_cnt_in      = free_cnt_ff - 1'b1;
            end else begin
               free_op.wr_en   = 1'b1;
               free_op.wr_idx  = idx_ff[IDX_W-1:0];
               free_op.wr_data = '{start: cur_ff.start + rnd_ff,
                                   length: cur_ff.length - rnd_ff};
            end
            used_op.wr_en   = 1'b1;
            used_op.wr_idx  = used_cnt_ff[IDX_W-1:0];
            used_op.wr_data = '{start: cur_ff.start, length: rnd_ff};
            used_cnt_in     = used_cnt_ff + 1'b1;
            aoff_in         = cur_ff.start;
            state_in        = S_DONE;
         end
         S_USCAN: begin
            if (idx_ff == used_cnt_ff) begin
               st_in    = ST_NOTALLOC;
               state_in = S_DONE;
            end else if (used_rd.start == off_ff && used_rd.length == size_ff) begin
               jdx_in   = idx_ff;
               idx_in   = '0;
               state_in = S_FSCAN;
            end else begin
               idx_in = idx_next;
            end
         end
         S_FSCAN: begin
            if (idx_ff == free_cnt_ff) begin
               state_in = S_FDECIDE;
            end else if (off_ff <= free_rd.start ||
                         (off_ff - free_rd.start) <= free_rd.length) begin
               cur_in   = free_rd;
               state_in = S_FDECIDE;
            end else begin
               idx_in = idx_next;
            end
         end
         S_FDECIDE: begin
            ins_mode = 1'b1;
            if (idx_ff != free_cnt_ff) begin
               if (off_ff >= cur_ff.start && (off_ff - cur_ff.start) == cur_ff.length) begin
                  ins_mode = 1'b0;
                  free_op.wr_en   = 1'b1;
                  free_op.wr_idx  = idx_ff[IDX_W-1:0];
                  free_op.wr_data = '{start: cur_ff.start,
                                      length: cur_ff.length + size_ff};
                  cur_in.length   = cur_ff.length + size_ff;
                  state_in        = S_FMERGE;
               end else if (cur_ff.start >= off_ff &&
                            (cur_ff.start - off_ff) == size_ff) begin
                  ins_mode = 1'b0;
                  free_op.wr_en   = 1'b1;
                  free_op.wr_idx  = idx_ff[IDX_W-1:0];
                  free_op.wr_data = '{start: off_ff, length: cur_ff.length + size_ff};
                  state_in        = S_DONE;
               end
            end
            if (ins_mode && free_cnt_ff >= CNT_W'(FREE_ENTRIES)) begin
               free_op  = '0;
               st_in    = ST_FULL;
               state_in = S_DONE;
            end else begin
               used_op.drop_en  = 1'b1;
               used_op.drop_idx = jdx_ff[IDX_W-1:0];
               used_cnt_in      = used_cnt_ff - 1'b1;
               if (ins_mode) begin
                  free_op.ins_en  = 1'b1;
                  free_op.wr_idx  = idx_ff[IDX_W-1:0];
                  free_op.wr_data = '{start: off_ff, length: size_ff};
                  free_cnt_in     = free_cnt_ff + 1'b1;
                  state_in        = S_DONE;
               end
            end
         end
         S_FMERGE: begin
            // absorb the following range when the extended one now touches it
            if (idx_next < free_cnt_ff &&
                (cur_ff.start + cur_ff.length) == free_rd_next.start) begin
               free_op.wr_en    = 1'b1;
               free_op.wr_idx   = idx_ff[IDX_W-1:0];
               free_op.wr_data  = '{start: cur_ff.start,
                                    length: cur_ff.length + free_rd_next.length};
               free_op.drop_en  = 1'b1;
               free_op.drop_idx = idx_next[IDX_W-1:0];
               free_cnt_in      = free_cnt_ff - 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_cnt_ff  <= '0;
         used_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         pool_ff      <= '0;
         gran_ff      <= GRAN_BITS'(1);
      end else begin
         state_ff    <= state_in;
         free_cnt_ff <= free_cnt_in;
         used_cnt_ff <= used_cnt_in;
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_POOL_SIZE:    pool_ff <= csr_wdata;
               CSR_GRANULE_SIZE: gran_ff <= csr_wdata[GRAN_BITS-1:0];
               default:          pool_ff <= pool_ff;
            endcase
         end
      end
   end

   // transaction payload and scratch registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         type_ff <= req_type;
         size_ff <= req_request_size;
         off_ff  <= req_free_offset;
      end
      rnd_ff  <= rnd_in;
      idx_ff  <= idx_in;
      jdx_ff  <= jdx_in;
      cur_ff  <= cur_in;
      st_ff   <= st_in;
      aoff_ff <= aoff_in;
      gsz_ff  <= gsz_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_status_ff <= st_ff;
         rsp_off_ff    <= aoff_ff;
         rsp_gsz_ff    <= (type_ff == REQ_ALLOC) ? gsz_ff : '0;
      end
   end

   // free table: write, insert with shift up, drop with shift down
   always_ff @(posedge clock) begin
      for (int k = 0; k < FREE_ENTRIES; k++) begin
         if (free_op.ins_en) begin
            if (IDX_W'(k) == free_op.wr_idx) begin
               free_tbl_ff[k] <= free_op.wr_data;
            end else if (k > 0 && IDX_W'(k) > free_op.wr_idx) begin
               free_tbl_ff[k] <= free_tbl_ff[(k > 0) ? k - 1 : 0];
            end
         end else if (free_op.wr_en && IDX_W'(k) == free_op.wr_idx) begin
            free_tbl_ff[k] <= free_op.wr_data;
         end else if (free_op.drop_en && IDX_W'(k) >= free_op.drop_idx &&
                      k < FREE_ENTRIES - 1) begin
            free_tbl_ff[k] <= free_tbl_ff[(k < FREE_ENTRIES - 1) ? k + 1 : k];
         end
      end
   end

   // allocated table: append or drop with shift down
   always_ff @(posedge clock) begin
      for (int k = 0; k < USED_ENTRIES; k++) begin
         if (used_op.wr_en && IDX_W'(k) == used_op.wr_idx) begin
            used_tbl_ff[k] <= used_op.wr_data;
         end else if (used_op.drop_en && IDX_W'(k) >= used_op.drop_idx &&
                      k < USED_ENTRIES - 1) begin
            used_tbl_ff[k] <= used_tbl_ff[(k < USED_ENTRIES - 1) ? k + 1 : k];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_alloc_offset = rsp_off_ff;
   assign rsp_granted_size = rsp_gsz_ff;

endmodule

`default_nettype wire
